### hdl/fpls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Finder pattern line scanner package
// Widths, constants and the 1:1:3:1:1 run ratio check shared by the scanner.
// ----------------------------------------------------------------------------
package fpls_pkg;

    localparam int PIX_W       = 8;
    localparam int POS_W       = 10;
    localparam int BND_W       = POS_W + 1;
    localparam int BND_COUNT   = 6;
    localparam int CNT_W       = 3;
    localparam int LINE_LENGTH = 1024;
    localparam int LEN_W       = $clog2(4096) + 1;
    localparam int RUN_W       = BND_W + 1;
    localparam int SUM_W       = 17;
    localparam int DIFF_W      = SUM_W + 1;
    localparam int CMP_W       = SUM_W + 2;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(10);
    localparam logic [LEN_W-1:0] LINE_LIMIT      = LEN_W'(LINE_LENGTH);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [BND_W-1:0] bnd_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef bnd_t [BND_COUNT-1:0] bnd_vec_t;

    // Each of runs 1 to 4 must lie within a quarter of the mean, all scaled by 15.
    function automatic logic ratio_ok(input bnd_vec_t b);
        logic signed [RUN_W-1:0]  r [5];
        logic signed [SUM_W-1:0]  sum4;
        logic signed [SUM_W-1:0]  m;
        logic signed [SUM_W-1:0]  rx;
        logic signed [SUM_W-1:0]  x;
        logic signed [DIFF_W-1:0] d;
        logic        [DIFF_W-1:0] absd;
        logic        [CMP_W-1:0]  q;
        logic                     ok;
        for (int i = 0; i < 5; i++)
        begin
            r[i] = $signed({1'b0, b[i+1]}) - $signed({1'b0, b[i]});
        end
        sum4 = SUM_W'(r[0]) + SUM_W'(r[1]) + SUM_W'(r[3]) + SUM_W'(r[4]);
        m    = (sum4 <<< 1) + sum4 + SUM_W'(r[2]);
        ok   = !m[SUM_W-1];
        for (int i = 1; i < 5; i++)
        begin
            rx = SUM_W'(r[i]);
            if (i == 2)
            begin
                x = (rx <<< 2) + rx;
            end
            else
            begin
                x = (rx <<< 4) - rx;
            end
            d    = DIFF_W'(m) - DIFF_W'(x);
            absd = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            q    = {absd[CMP_W-3:0], 2'b00};
            if (q > {2'b00, m})
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

### hdl/finder_pattern_line_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Finder pattern line scanner
// Finds a 1:1:3:1:1 black/white run pattern on one grey image line.
// ----------------------------------------------------------------------------
// Usage: pixels of a line enter in order on the input channel (in_valid,
// in_stall), each with its position and a line_last flag. A request is taken
// at a rising edge with in_valid high and in_stall low. Each pixel is held in
// an input register and processed from there by the run tracker and the ratio
// check, so one pixel can be taken in every cycle while in_stall stays low.
// Only the last pixel of a line gives a result: found, pattern_start and
// pattern_end are registered on the output channel (out_valid, out_stall) as
// that pixel leaves the input register, and they stay until the receiver takes
// them. While a result waits under out_stall, ordinary pixels still flow; a
// second line end holds in the input register and in_stall rises. The black
// threshold is loaded by cfg_write_enable and cfg_write_data; the user must
// write it only while the block is idle; the block does not enforce it. Reset
// empties both registers, clears the line state and sets the threshold to 10;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module finder_pattern_line_scanner
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_enable,
    input  fpls_pkg::pix_t     cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  fpls_pkg::pix_t     pixel_value,
    input  fpls_pkg::pos_t     pixel_position,
    input  logic               line_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output fpls_pkg::pos_t     pattern_start,
    output fpls_pkg::pos_t     pattern_end
);
    import fpls_pkg::*;

    pix_t     threshold_reg;
    logic     in_valid_reg;
    pix_t     in_value_reg;
    pos_t     in_pos_reg;
    logic     in_last_reg;
    bnd_vec_t store_reg;
    bnd_vec_t store_next;
    cnt_t     count_reg;
    cnt_t     count_next;
    logic     black_reg;
    logic     black_next;
    logic     done_reg;
    logic     done_next;
    logic     out_valid_reg;
    logic     found_reg;
    pos_t     start_reg;
    pos_t     end_reg;

    logic     advance;
    logic     active;
    logic     black;
    logic     add1;
    logic     add2;
    logic     check;
    logic     pass;
    bnd_t     p0;
    bnd_t     p1;
    cnt_t     pos2;
    bnd_vec_t vec;
    bnd_t     end_bnd;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        active = !done_reg && ({{(LEN_W-POS_W){1'b0}}, in_pos_reg} < LINE_LIMIT);
        black  = in_value_reg < threshold_reg;
        p0     = {1'b0, in_pos_reg};
        p1     = BND_W'({1'b0, in_pos_reg} + BND_W'(1));
        if (count_reg == '0)
        begin
            add1 = active && black;
            add2 = 1'b0;
        end
        else
        begin
            add1 = active && (black_reg != black);
            add2 = active && in_last_reg;
        end

        check = (count_reg == CNT_W'(5) && (add1 || add2))
             || (count_reg == CNT_W'(4) && add1 && add2);
        vec = store_reg;
        if (count_reg == CNT_W'(4))
        begin
            vec[4] = p0;
        end
        vec[5] = (count_reg == CNT_W'(5) && add1) ? p0 : p1;
        pass   = ratio_ok(vec);

        store_next = store_reg;
        count_next = count_reg;
        black_next = add1 ? black : black_reg;
        done_next  = done_reg;
        pos2       = count_reg + CNT_W'(add1);
        if (check)
        begin
            if (pass)
            begin
                store_next = vec;
                count_next = CNT_W'(6);
                done_next  = 1'b1;
            end
            else
            begin
                store_next[0] = vec[2];
                store_next[1] = vec[3];
                store_next[2] = vec[4];
                store_next[3] = vec[5];
                store_next[4] = '0;
                store_next[5] = '0;
                count_next    = CNT_W'(4);
                if (count_reg == CNT_W'(5) && add1 && add2)
                begin
                    store_next[4] = p1;
                    count_next    = CNT_W'(5);
                end
            end
        end
        else
        begin
            for (int i = 0; i < BND_COUNT; i++)
            begin
                if (add1 && count_reg == CNT_W'(i))
                begin
                    store_next[i] = p0;
                end
                if (add2 && pos2 == CNT_W'(i))
                begin
                    store_next[i] = p1;
                end
            end
            count_next = count_reg + CNT_W'(add1) + CNT_W'(add2);
        end
        end_bnd = store_next[5] - BND_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            in_valid_reg  <= 1'b0;
            store_reg     <= '0;
            count_reg     <= '0;
            black_reg     <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                threshold_reg <= cfg_write_data;
            end
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                if (in_last_reg)
                begin
                    store_reg <= '0;
                    count_reg <= '0;
                    black_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end
                else
                begin
                    store_reg <= store_next;
                    count_reg <= count_next;
                    black_reg <= black_next;
                    done_reg  <= done_next;
                end
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_value_reg <= pixel_value;
            in_pos_reg   <= pixel_position;
            in_last_reg  <= line_last;
        end
        if (advance && in_last_reg)
        begin
            found_reg <= done_next;
            start_reg <= done_next ? store_next[0][POS_W-1:0] : '0;
            end_reg   <= done_next ? end_bnd[POS_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign pattern_start = start_reg;
    assign pattern_end   = end_reg;

endmodule
